/* src/tsb_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and codes for the TCP segment header builder.
package tsb_pkg;

  // Segment limits and fixed header fields.
  localparam logic [15:0] MAX_PAYLOAD_BYTES = 16'd65515;
  localparam logic [15:0] TCP_WINDOW        = 16'd65530;
  localparam logic [15:0] TCP_PROTOCOL      = 16'd6;
  localparam logic [15:0] HEADER_BYTES      = 16'd20;
  localparam logic [3:0]  DATA_OFFSET       = 4'd5;

  // Input item codes.
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  // Result word kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_HDR  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_SRC_ADDR = 2'd0;
  localparam logic [1:0] REG_DST_ADDR = 2'd1;
  localparam logic [1:0] REG_SRC_PORT = 2'd2;
  localparam logic [1:0] REG_DST_PORT = 2'd3;

  // Header word positions.
  localparam logic [2:0] HDR_PORTS    = 3'd0;
  localparam logic [2:0] HDR_SEQ      = 3'd1;
  localparam logic [2:0] HDR_ACK      = 3'd2;
  localparam logic [2:0] HDR_CTRL     = 3'd3;
  localparam logic [2:0] HDR_LAST_IDX = 3'd4;

  // Queue depths.
  localparam int JQ_DEPTH = 4;
  localparam int OF_DEPTH = 2;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
  } cfg_t;

  // One unit of work for the back end: an echoed byte, a header, or both.
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  data_byte;
    logic        has_hdr;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [15:0] sum;
    logic [15:0] count;
    logic        ovf;
  } job_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] data;
    logic        last;
    logic        ovf;
  } out_word_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BYTE,
    BK_HDR
  } back_st_t;

endpackage

/* src/tsb_front.sv */
`timescale 1ns / 1ps
// Front end: takes input items, tracks the open segment and issues jobs.
module tsb_front import tsb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        action,
  input  logic [31:0] seq_value,
  input  logic [31:0] ack_value,
  input  logic [7:0]  flag_bits,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        job_push,
  output job_t        job
);

  logic        in_seg_r, in_seg_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] count_r, count_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] ack_r, ack_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic        ovf_r, ovf_nxt;
  logic [15:0] byte_word;

  // Ones-complement add with the end-around carry folded back in.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Even-numbered payload bytes are the high half of a 16-bit word.
  assign byte_word = count_r[0] ? {8'd0, data_byte} : {data_byte, 8'd0};

  always_comb begin
    in_seg_nxt = in_seg_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    seq_nxt    = seq_r;
    ack_nxt    = ack_r;
    flags_nxt  = flags_r;
    ovf_nxt    = ovf_r;
    job        = '0;
    job_push   = 1'b0;
    if (accept) begin
      if (action == ACT_BEGIN) begin
        seq_nxt    = seq_value;
        ack_nxt    = ack_value;
        flags_nxt  = flag_bits;
        sum_nxt    = '0;
        count_nxt  = '0;
        ovf_nxt    = 1'b0;
        in_seg_nxt = !last;
        job.has_hdr = last;
      end else if (in_seg_r) begin
        if (count_r < MAX_PAYLOAD_BYTES) begin
          sum_nxt        = oc_add(sum_r, byte_word);
          count_nxt      = count_r + 16'd1;
          job.has_byte   = 1'b1;
          job.data_byte  = data_byte;
        end else begin
          ovf_nxt = 1'b1;
        end
        job.has_hdr = last;
        if (last) begin
          in_seg_nxt = 1'b0;
        end
      end
      job.seq   = seq_nxt;
      job.ack   = ack_nxt;
      job.flags = flags_nxt;
      job.sum   = sum_nxt;
      job.count = count_nxt;
      job.ovf   = ovf_nxt;
      job_push  = job.has_byte || job.has_hdr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_seg_r <= 1'b0;
    end else begin
      in_seg_r <= in_seg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    count_r <= count_nxt;
    seq_r   <= seq_nxt;
    ack_r   <= ack_nxt;
    flags_r <= flags_nxt;
    ovf_r   <= ovf_nxt;
  end

endmodule

/* src/tsb_jobq.sv */
`timescale 1ns / 1ps
// Short job queue that decouples the front end from the back end.
module tsb_jobq import tsb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output job_t rd_job,
  output logic empty
);

  localparam int PW = $clog2(JQ_DEPTH);
  localparam int CW = $clog2(JQ_DEPTH + 1);

  job_t          mem_r [JQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(JQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

/* src/tsb_back.sv */
`timescale 1ns / 1ps
// Back end: turns jobs into result words and accumulates the checksum.
module tsb_back import tsb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        jq_empty,
  input  job_t        jq_job,
  output logic        jq_pop,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [31:0] out_data,
  output logic        out_last,
  output logic        out_overflow
);

  localparam int OPW = $clog2(OF_DEPTH);
  localparam int OCW = $clog2(OF_DEPTH + 1);

  back_st_t    st_r, st_nxt;
  job_t        cur_r, cur_nxt;
  logic [2:0]  widx_r, widx_nxt;
  logic [19:0] acc_r, acc_nxt;
  logic        emit, done_job;
  out_word_t   wr_word;
  out_word_t   hdr_word;
  logic [31:0] ctrl_word;
  logic [15:0] t0, t1, t2, t3;
  logic [19:0] term_sum;
  logic [16:0] fold1;
  logic [15:0] fold2;

  out_word_t      of_mem_r [OF_DEPTH];
  logic [OPW-1:0] of_wr_r, of_rd_r;
  logic [OCW-1:0] of_cnt_r;
  logic           of_full, of_pop;

  assign ctrl_word = {DATA_OFFSET, 4'd0, cur_r.flags, TCP_WINDOW};

  // Checksum terms are spread over the first four header words.
  always_comb begin
    case (widx_r)
      HDR_PORTS: begin
        t0 = cfg.sport;
        t1 = cfg.dport;
        t2 = cfg.src_addr[31:16];
        t3 = cfg.src_addr[15:0];
      end
      HDR_SEQ: begin
        t0 = cur_r.seq[31:16];
        t1 = cur_r.seq[15:0];
        t2 = cfg.dst_addr[31:16];
        t3 = cfg.dst_addr[15:0];
      end
      HDR_ACK: begin
        t0 = cur_r.ack[31:16];
        t1 = cur_r.ack[15:0];
        t2 = TCP_PROTOCOL;
        t3 = HEADER_BYTES + cur_r.count;
      end
      HDR_CTRL: begin
        t0 = ctrl_word[31:16];
        t1 = ctrl_word[15:0];
        t2 = '0;
        t3 = '0;
      end
      default: begin
        t0 = '0;
        t1 = '0;
        t2 = '0;
        t3 = '0;
      end
    endcase
    term_sum = {4'd0, t0} + {4'd0, t1} + {4'd0, t2} + {4'd0, t3};
  end

  // Sixteen 16-bit terms at most fit in 20 bits; two folds bring it to 16.
  assign fold1 = {1'b0, acc_r[15:0]} + {13'd0, acc_r[19:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  always_comb begin
    hdr_word.kind = KIND_HDR;
    hdr_word.ovf  = cur_r.ovf;
    hdr_word.last = 1'b0;
    case (widx_r)
      HDR_PORTS: hdr_word.data = {cfg.sport, cfg.dport};
      HDR_SEQ:   hdr_word.data = cur_r.seq;
      HDR_ACK:   hdr_word.data = cur_r.ack;
      HDR_CTRL:  hdr_word.data = ctrl_word;
      default: begin
        hdr_word.data = {~fold2, 16'd0};
        hdr_word.last = 1'b1;
      end
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    widx_nxt = widx_r;
    acc_nxt  = acc_r;
    emit     = 1'b0;
    done_job = 1'b0;
    jq_pop   = 1'b0;
    wr_word  = hdr_word;
    unique case (st_r)
      BK_IDLE: begin
        done_job = 1'b1;
      end
      BK_BYTE: begin
        wr_word.kind = KIND_BYTE;
        wr_word.data = {24'd0, cur_r.data_byte};
        wr_word.last = 1'b0;
        wr_word.ovf  = 1'b0;
        if (!of_full) begin
          emit = 1'b1;
          if (cur_r.has_hdr) begin
            st_nxt   = BK_HDR;
            widx_nxt = HDR_PORTS;
          end else begin
            done_job = 1'b1;
          end
        end
      end
      BK_HDR: begin
        if (!of_full) begin
          emit     = 1'b1;
          acc_nxt  = acc_r + term_sum;
          widx_nxt = widx_r + 3'd1;
          done_job = (widx_r == HDR_LAST_IDX);
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
    if (done_job) begin
      if (!jq_empty) begin
        jq_pop   = 1'b1;
        cur_nxt  = jq_job;
        widx_nxt = HDR_PORTS;
        acc_nxt  = {4'd0, jq_job.sum};
        st_nxt   = jq_job.has_byte ? BK_BYTE : BK_HDR;
      end else begin
        st_nxt = BK_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    widx_r <= widx_nxt;
    acc_r  <= acc_nxt;
  end

  // Output queue: lets a new word be built while the previous one waits.
  assign of_full = (of_cnt_r == OCW'(OF_DEPTH));
  assign empty   = (of_cnt_r == '0);
  assign of_pop  = pop && !empty;

  assign out_kind     = of_mem_r[of_rd_r].kind;
  assign out_data     = of_mem_r[of_rd_r].data;
  assign out_last     = of_mem_r[of_rd_r].last;
  assign out_overflow = of_mem_r[of_rd_r].ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wr_r  <= '0;
      of_rd_r  <= '0;
      of_cnt_r <= '0;
    end else begin
      if (emit) begin
        of_wr_r <= of_wr_r + OPW'(1);
      end
      if (of_pop) begin
        of_rd_r <= of_rd_r + OPW'(1);
      end
      if (emit && !of_pop) begin
        of_cnt_r <= of_cnt_r + OCW'(1);
      end else if (of_pop && !emit) begin
        of_cnt_r <= of_cnt_r - OCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      of_mem_r[of_wr_r] <= wr_word;
    end
  end

  a_of_bound: assert property (@(posedge clk) disable iff (!rst_n)
    of_cnt_r <= OCW'(OF_DEPTH))
    else $error("output queue count out of range");

  a_hdr_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_HDR) |-> (widx_r <= HDR_LAST_IDX))
    else $error("header word index out of range");

  a_last_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && wr_word.last) |-> (wr_word.kind == KIND_HDR))
    else $error("segment end marked on a payload word");

  a_byte_job: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_BYTE) |-> cur_r.has_byte)
    else $error("byte phase entered for a job without a byte");

endmodule

/* src/tcp_segment_header_builder.sv */
`timescale 1ns / 1ps
// Top level of the TCP segment header builder: configuration and wiring.
//
// Input side is a queue write port: a word is taken on a clock edge where
// push is high and full is low. A begin word (in_action low) opens a segment
// with its sequence number, acknowledgment number and flag byte; each payload
// word (in_action high) carries one byte. in_last closes the segment.
// Result side is a queue read port: while empty is low the oldest word sits
// on the out_ ports and is taken on an edge where pop is high.
// Every accepted payload byte below the length limit comes back as one echoed
// word. When a segment closes, five header words follow: ports, sequence,
// acknowledgment, offset/flags/window, then checksum with a zero urgent
// pointer; out_last marks the fifth. Bytes past the limit are dropped and
// out_overflow is set on that segment's header words.
// A result word passes the job queue, the back end and the output queue. Payload
// flows at one byte per cycle while the output queue has room. Closing a segment
// holds the back end for its header words while the four-entry job queue takes
// later input words; full rises once it runs out. If pop stays low the two-entry
// output queue fills, the back end holds, the job queue fills and full rises;
// nothing is lost. Synchronous reset empties all queues, closes any open segment
// and clears the address and port registers, written through cfg_we, cfg_index
// and cfg_data; the user must do so only while idle; the block does not check.
module tcp_segment_header_builder import tsb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_action,
  input  logic [31:0] in_seq_value,
  input  logic [31:0] in_ack_value,
  input  logic [7:0]  in_flag_bits,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [31:0] out_data,
  output logic        out_last,
  output logic        out_overflow,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic accept;
  logic job_push;
  job_t fe_job;
  logic jq_full, jq_empty, jq_pop;
  job_t jq_job;

  // Register writes; port registers keep the low half of the data word.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_ADDR: cfg_nxt.src_addr = cfg_data;
        REG_DST_ADDR: cfg_nxt.dst_addr = cfg_data;
        REG_SRC_PORT: cfg_nxt.sport    = cfg_data[15:0];
        REG_DST_PORT: cfg_nxt.dport    = cfg_data[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end can always take an item as long as a job slot is free.
  assign full   = jq_full;
  assign accept = push && !jq_full;

  tsb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_action),
    .seq_value (in_seq_value),
    .ack_value (in_ack_value),
    .flag_bits (in_flag_bits),
    .data_byte (in_data_byte),
    .last      (in_last),
    .job_push  (job_push),
    .job       (fe_job)
  );

  tsb_jobq u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_job (fe_job),
    .full   (jq_full),
    .pop    (jq_pop),
    .rd_job (jq_job),
    .empty  (jq_empty)
  );

  tsb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .jq_empty     (jq_empty),
    .jq_job       (jq_job),
    .jq_pop       (jq_pop),
    .empty        (empty),
    .pop          (pop),
    .out_kind     (out_kind),
    .out_data     (out_data),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

endmodule
